// ----- design/assert_macros.svh -----
// Assertion macros for the port-level checker file.
// Include once per compilation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an antecedent implies a consequent in the same cycle.
`define CHK_IMPL(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
// Check that an antecedent implies a consequent in the next cycle.
`define CHK_NEXT(label, clk, rstn, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
`endif

// ----- design/bspc_pkg.sv -----
// Package for the BLDC speed PI controller: constants, types, register codes.
// No dependencies.
package bspc_pkg;
    localparam int unsigned DutyW = 12;
    localparam int unsigned IntvW = 24;
    localparam logic [11:0] KpLow  = 12'd500;
    localparam logic [11:0] KpHigh = 12'd4000;
    localparam int unsigned PiShift = 14;
    localparam logic [9:0]  KhzScale = 10'd1000;
    localparam logic [23:0] Max24 = 24'hFFFFFF;
    // Divide by 3 as multiply by ceil(2^25/3) and shift; exact below 2^25
    localparam logic [23:0] Recip3 = 24'hAAAAAB;
    localparam int unsigned Recip3Shift = 25;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 17;

    typedef enum logic [2:0] {
        REG_MIN_DUTY    = 3'd0,
        REG_GAIN_SWITCH = 3'd1,
        REG_PWM_PERIOD  = 3'd2,
        REG_MAX_HALL    = 3'd3,
        REG_CNT_FREQ    = 3'd4,
        REG_CTRL_INTV   = 3'd5,
        REG_SAMPLE_INTV = 3'd6,
        REG_SPEED_DIV   = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCHED,
        ST_DIV_DUTY,
        ST_HALL_MUL,
        ST_DIV_HALL,
        ST_NUM_MUL,
        ST_DIV_EXP,
        ST_PI_MUL,
        ST_PI_SUM,
        ST_DIV3,
        ST_APPLY,
        ST_OUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic sched;
        logic div_start;
        logic [1:0] div_sel;   // 0 duty, 1 hall, 2 expected
        logic duty_done;
        logic hall_done;
        logic exp_done;
        logic pi_mul;
        logic pi_sum;
        logic div3;
        logic apply;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic div_busy;
        logic take_sp;
        logic run_pi;
    } stat_t;

    localparam logic [1:0] DivDuty = 2'd0;
    localparam logic [1:0] DivHall = 2'd1;
    localparam logic [1:0] DivExp  = 2'd2;
endpackage

// ----- design/bspc_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bspc_pkg only through its users; standalone.
module bspc_div #(
    parameter int unsigned W = 48
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         busy,
    output logic [W-1:0] quo
);
    localparam int unsigned CW = $clog2(W + 1);
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    trial;

    // Shift one numerator bit in per cycle
    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg, q_reg[W-1]} - {1'b0, d_reg};
        if (start)
        begin
            rem_next = '0;
            q_next   = num;
            d_next   = den;
            cnt_next = CW'(W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                q_next   = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], q_reg[W-1]};
                q_next   = {q_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign busy = (cnt_reg != '0);
    assign quo  = q_reg;
endmodule

// ----- design/bspc_ctrl.sv -----
// Controller state machine sequencing setpoint and PI steps.
// Depends on bspc_pkg.
module bspc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_fire,
    input  bspc_pkg::stat_t   stat,
    output bspc_pkg::cmd_t    cmd,
    output logic              in_ready,
    output logic              out_valid
);
    bspc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bspc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bspc_pkg::ST_IDLE:     if (in_fire) state_next = bspc_pkg::ST_SCHED;
            bspc_pkg::ST_SCHED:
                if (stat.take_sp) state_next = bspc_pkg::ST_DIV_DUTY;
                else if (stat.run_pi) state_next = bspc_pkg::ST_PI_MUL;
                else state_next = bspc_pkg::ST_OUT;
            bspc_pkg::ST_DIV_DUTY: if (!stat.div_busy) state_next = bspc_pkg::ST_HALL_MUL;
            bspc_pkg::ST_HALL_MUL: state_next = bspc_pkg::ST_DIV_HALL;
            bspc_pkg::ST_DIV_HALL: if (!stat.div_busy) state_next = bspc_pkg::ST_NUM_MUL;
            bspc_pkg::ST_NUM_MUL:  state_next = bspc_pkg::ST_DIV_EXP;
            bspc_pkg::ST_DIV_EXP:
                if (!stat.div_busy)
                    state_next = stat.run_pi ? bspc_pkg::ST_PI_MUL : bspc_pkg::ST_OUT;
            bspc_pkg::ST_PI_MUL:   state_next = bspc_pkg::ST_PI_SUM;
            bspc_pkg::ST_PI_SUM:   state_next = bspc_pkg::ST_DIV3;
            bspc_pkg::ST_DIV3:     state_next = bspc_pkg::ST_APPLY;
            bspc_pkg::ST_APPLY:    state_next = bspc_pkg::ST_OUT;
            bspc_pkg::ST_OUT:      if (out_fire) state_next = bspc_pkg::ST_IDLE;
            default:               state_next = bspc_pkg::ST_IDLE;
        endcase
    end

    // Outputs; divider start fires on entry to each divide state
    always_comb
    begin
        cmd = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            bspc_pkg::ST_IDLE:  in_ready = 1'b1;
            bspc_pkg::ST_SCHED:
            begin
                cmd.sched = 1'b1;
                if (stat.take_sp)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel = bspc_pkg::DivDuty;
                end
            end
            bspc_pkg::ST_DIV_DUTY: cmd.duty_done = !stat.div_busy;
            bspc_pkg::ST_HALL_MUL:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel = bspc_pkg::DivHall;
            end
            bspc_pkg::ST_DIV_HALL: cmd.hall_done = !stat.div_busy;
            bspc_pkg::ST_NUM_MUL:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel = bspc_pkg::DivExp;
            end
            bspc_pkg::ST_DIV_EXP: cmd.exp_done = !stat.div_busy;
            bspc_pkg::ST_PI_MUL:  cmd.pi_mul = 1'b1;
            bspc_pkg::ST_PI_SUM:  cmd.pi_sum = 1'b1;
            bspc_pkg::ST_DIV3:    cmd.div3 = 1'b1;
            bspc_pkg::ST_APPLY:   cmd.apply = 1'b1;
            bspc_pkg::ST_OUT:     out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

// ----- design/bspc_dp.sv -----
// Datapath: config registers, period counters, setpoint and PI arithmetic.
// Depends on bspc_pkg and bspc_div.
module bspc_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bspc_pkg::CfgIdxW-1:0]  cfg_idx,
    input  logic [bspc_pkg::CfgDataW-1:0] cfg_data,
    input  logic                          in_fire,
    input  logic [14:0]                   pot_sum,
    input  logic [23:0]                   meas_in,
    input  bspc_pkg::cmd_t                cmd,
    output bspc_pkg::stat_t               stat,
    output logic [11:0]                   applied_duty,
    output logic                          control_ran,
    output logic                          setpoint_updated,
    output logic [1:0]                    clamp_state
);
    localparam int unsigned DW = 48;

    logic [11:0] min_duty_reg, gsw_reg, period_reg;
    logic [15:0] hall_rate_reg, samp_intv_reg;
    logic [16:0] freq_reg;
    logic [7:0]  ctrl_intv_reg, div_reg;

    logic [7:0]  ctick_reg;
    logic [15:0] stick_reg;
    logic        pend_reg, have_sp_reg, hg_reg;
    logic [11:0] desired_reg, duty_out_reg;
    logic [23:0] exp_reg;
    logic signed [31:0] integ_reg;
    logic        ran_reg, upd_reg;
    logic [1:0]  clamp_reg;
    logic [14:0] pot_reg;
    logic [23:0] meas_reg;
    logic        take_sp_reg, run_pi_reg;

    logic [27:0] hall_prod;            // hall rate times desired duty, 16x12
    logic [26:0] freq_prod;            // freq*1000
    logic [31:0] hall_reg;
    logic signed [37:0] kpe_reg;       // Kp*e
    logic signed [24:0] e_reg;
    logic signed [38:0] sum_reg;       // floor-shifted PI sum, sign kept here
    logic        neg_reg;
    logic [23:0] exp_new;
    logic [23:0] mag3;                 // |PI sum|, below 2^23 for all inputs
    logic [47:0] q3_prod;
    logic [23:0] q3_reg;               // |PI sum| / 3

    logic [DW-1:0] dnum, dden, dquo;
    logic          dbusy;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_duty_reg  <= 12'd410;
            gsw_reg       <= 12'd1024;
            period_reg    <= 12'd4095;
            hall_rate_reg <= 16'd1000;
            freq_reg      <= 17'd72000;
            ctrl_intv_reg <= 8'd9;
            samp_intv_reg <= 16'd99;
            div_reg       <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (bspc_pkg::reg_idx_t'(cfg_idx))
                bspc_pkg::REG_MIN_DUTY:    min_duty_reg  <= cfg_data[11:0];
                bspc_pkg::REG_GAIN_SWITCH: gsw_reg       <= cfg_data[11:0];
                bspc_pkg::REG_PWM_PERIOD:  period_reg    <= cfg_data[11:0];
                bspc_pkg::REG_MAX_HALL:    hall_rate_reg <= cfg_data[15:0];
                bspc_pkg::REG_CNT_FREQ:    freq_reg      <= cfg_data[16:0];
                bspc_pkg::REG_CTRL_INTV:   ctrl_intv_reg <= cfg_data[7:0];
                bspc_pkg::REG_SAMPLE_INTV: samp_intv_reg <= cfg_data[15:0];
                bspc_pkg::REG_SPEED_DIV:   div_reg       <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Dividend products, loaded straight into the divider on start
    assign hall_prod = 28'(hall_rate_reg) * 28'(desired_reg);
    assign freq_prod = 27'(freq_reg) * 27'(bspc_pkg::KhzScale);

    // Divider operand select
    always_comb
    begin
        case (cmd.div_sel)
            bspc_pkg::DivDuty:
            begin
                dnum = DW'(pot_reg[14:3]);
                dden = DW'(div_reg);
            end
            bspc_pkg::DivHall:
            begin
                dnum = DW'(hall_prod);
                dden = DW'(period_reg);
            end
            default:
            begin
                dnum = DW'(freq_prod);
                dden = DW'(hall_reg);
            end
        endcase
    end

    bspc_div #(.W(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (dnum),
        .den   (dden),
        .busy  (dbusy),
        .quo   (dquo)
    );

    logic [7:0]  ctick_inc;
    logic [15:0] stick_inc;
    logic [11:0] duty_q;
    logic signed [25:0] integ_w;
    logic signed [32:0] integ_sat;
    logic signed [38:0] pi_raw;
    logic signed [26:0] corr, c8;
    logic signed [26:0] applied_w;

    assign ctick_inc = ctick_reg + 8'd1;
    assign stick_inc = stick_reg + 16'd1;
    assign duty_q = (div_reg == 8'd0) ? 12'hFFF : dquo[11:0];
    assign exp_new = (hall_reg == 32'd0 || dquo > DW'(bspc_pkg::Max24))
                     ? bspc_pkg::Max24 : dquo[23:0];
    assign integ_w = 26'(e_reg);
    assign integ_sat = 33'(integ_reg) + 33'(integ_w);
    assign pi_raw = kpe_reg + (hg_reg ? 39'(integ_reg) : 39'sd0);
    assign mag3 = sum_reg[38] ? 24'(-sum_reg) : 24'(sum_reg);
    assign q3_prod = 48'(mag3) * 48'(bspc_pkg::Recip3);
    assign corr = neg_reg ? -27'(q3_reg) : 27'(q3_reg);
    assign c8 = corr >>> 3;
    assign applied_w = 27'($signed({1'b0, desired_reg})) + c8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctick_reg <= '0;
            stick_reg <= '0;
            pend_reg <= 1'b0;
            have_sp_reg <= 1'b0;
            hg_reg <= 1'b0;
            desired_reg <= '0;
            duty_out_reg <= '0;
            exp_reg <= '0;
            integ_reg <= '0;
            ran_reg <= 1'b0;
            upd_reg <= 1'b0;
            clamp_reg <= '0;
            take_sp_reg <= 1'b0;
            run_pi_reg <= 1'b0;
        end
        else
        begin
            // Advance period counters and latch requests
            if (in_fire)
            begin
                ran_reg <= 1'b0;
                clamp_reg <= '0;
                take_sp_reg <= (stick_inc > samp_intv_reg) || !have_sp_reg;
                upd_reg <= (stick_inc > samp_intv_reg) || !have_sp_reg;
                stick_reg <= (stick_inc > samp_intv_reg) ? 16'd0 : stick_inc;
                ctick_reg <= (ctick_inc > ctrl_intv_reg) ? 8'd0 : ctick_inc;
                run_pi_reg <= ((ctick_inc > ctrl_intv_reg) || pend_reg)
                              && (meas_in != 24'd0);
                pend_reg <= ((ctick_inc > ctrl_intv_reg) || pend_reg)
                            && (meas_in == 24'd0);
            end
            if (cmd.duty_done)
            begin
                desired_reg <= (duty_q < min_duty_reg) ? min_duty_reg : duty_q;
                hg_reg <= !(((duty_q < min_duty_reg) ? min_duty_reg : duty_q) < gsw_reg);
                have_sp_reg <= 1'b1;
            end
            if (cmd.exp_done)
                exp_reg <= exp_new;
            // PI integral with 32-bit saturation
            if (cmd.pi_mul)
            begin
                if (integ_sat > 33'sh0_7FFF_FFFF)
                    integ_reg <= 32'sh7FFF_FFFF;
                else if (integ_sat < -33'sh0_8000_0000)
                    integ_reg <= 32'sh8000_0000;
                else
                    integ_reg <= integ_sat[31:0];
            end
            // Clamp and drive output; a floor above the period yields the period
            if (cmd.apply)
            begin
                ran_reg <= 1'b1;
                if (applied_w > 27'($signed({1'b0, period_reg}))
                    || min_duty_reg > period_reg)
                begin
                    duty_out_reg <= period_reg;
                    clamp_reg <= 2'd2;
                    integ_reg <= '0;
                end
                else if (applied_w < 27'($signed({1'b0, min_duty_reg})))
                begin
                    duty_out_reg <= min_duty_reg;
                    clamp_reg <= 2'd1;
                    integ_reg <= '0;
                end
                else
                    duty_out_reg <= applied_w[11:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pot_reg <= pot_sum;
            meas_reg <= meas_in;
        end
        if (cmd.hall_done)
            hall_reg <= (period_reg == 12'd0) ? 32'hFFFF_FFFF : dquo[31:0];
        // Error against the expected interval, fresh one when just computed
        if (cmd.exp_done)
            e_reg <= 25'($signed({1'b0, exp_new})) - 25'($signed({1'b0, meas_reg}));
        else if (cmd.sched)
            e_reg <= 25'($signed({1'b0, exp_reg})) - 25'($signed({1'b0, meas_reg}));
        if (cmd.pi_mul)
            kpe_reg <= 38'(e_reg) * 38'($signed({1'b0, hg_reg ? bspc_pkg::KpHigh
                                                         : bspc_pkg::KpLow}));
        if (cmd.pi_sum)
        begin
            sum_reg <= pi_raw >>> bspc_pkg::PiShift;
            neg_reg <= pi_raw[38];
        end
        if (cmd.div3)
            q3_reg <= 24'(q3_prod >> bspc_pkg::Recip3Shift);
    end

    assign stat.div_busy = dbusy;
    assign stat.take_sp = take_sp_reg;
    assign stat.run_pi = run_pi_reg;
    assign applied_duty = duty_out_reg;
    assign control_ran = ran_reg;
    assign setpoint_updated = upd_reg;
    assign clamp_state = clamp_reg;
endmodule

// ----- design/bldc_speed_pi_controller.sv -----
// BLDC speed PI controller with gain scheduling. One item per PWM period.
// A setpoint costs three passes of the shared iterative divider, for the duty,
// the hall rate and the expected interval; a PI step alone uses no divider pass.
// One item is in work at a time; the next is accepted in the cycle after the result transfers.
// Reset (rst_n, async low) loads register defaults and clears control state;
// payload and divider registers are not reset.
module bldc_speed_pi_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bspc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [bspc_pkg::CfgDataW-1:0] cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [39:0]                   s_tdata,   // pot_sum[14:0], measured_interval[38:15]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata    // applied_duty[11:0], control_ran[12],
                                                     // setpoint_updated[13], clamp_state[15:14]
);
    bspc_pkg::cmd_t  cmd;
    bspc_pkg::stat_t stat;
    logic in_fire, out_fire;
    logic [11:0] duty;
    logic ran, upd;
    logic [1:0] clamp;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    bspc_ctrl u_ctrl (
        .clk, .rst_n, .in_fire, .out_fire, .stat, .cmd,
        .in_ready (s_tready),
        .out_valid (m_tvalid)
    );

    bspc_dp u_dp (
        .clk, .rst_n,
        .cfg_we, .cfg_idx (cfg_index), .cfg_data,
        .in_fire,
        .pot_sum (s_tdata[14:0]),
        .meas_in (s_tdata[38:15]),
        .cmd, .stat,
        .applied_duty (duty),
        .control_ran (ran),
        .setpoint_updated (upd),
        .clamp_state (clamp)
    );

    assign m_tdata = {clamp, upd, ran, duty};
endmodule

// ----- design/bspc_checker.sv -----
// Port-level checker for the speed controller, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module bspc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    `CHK_IMPL(a_no_overlap, clk, rst_n, m_tvalid, !s_tready, "input taken during result")
    `CHK_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    `CHK_IMPL(a_clamp_code, clk, rst_n, m_tvalid, m_tdata[15:14] != 2'd3, "bad clamp code")
    `CHK_IMPL(a_clamp_ran, clk, rst_n, m_tvalid && !m_tdata[12], m_tdata[15:14] == 2'd0, "clamp without PI")
endmodule

bind bldc_speed_pi_controller bspc_checker u_chk (
    .clk, .rst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

// ----- bench/tb_top.sv -----
// Self-checking bench for the BLDC speed PI controller: a stream driver,
// a result monitor and a behavioral predictor of the scheduling and PI path.
// Depends on bspc_pkg and bldc_speed_pi_controller.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [bspc_pkg::CfgIdxW-1:0] cfg_index = '0;
    logic [bspc_pkg::CfgDataW-1:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [39:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [15:0] m_tdata;

    always #6 clk = ~clk;

    bldc_speed_pi_controller dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    typedef struct packed {
        logic [23:0] meas;
        logic [14:0] pot;
    } period_in_t;

    typedef struct packed {
        logic [1:0]  clamp;
        logic        sp_upd;
        logic        ran;
        logic [11:0] duty;
    } period_out_t;

    // controller registers as the bench believes them
    logic [11:0] r_min_duty, r_gain_sw, r_period;
    logic [15:0] r_hall_rate, r_sample_intv;
    logic [16:0] r_freq_khz;
    logic [7:0]  r_ctrl_intv, r_divider;
    // mirrored controller state
    logic [7:0]  m_ctrl_cnt;
    logic [15:0] m_samp_cnt;
    logic        m_pending, m_have_sp, m_high_gain;
    logic [11:0] m_desired, m_duty;
    logic [23:0] m_expected;
    longint      m_integ;

    period_in_t  pending_periods[$];
    period_out_t expected_results[$];
    int          mismatch_count = 0;
    int          in_idle_pct = 0;
    int          out_stall_pct = 0;
    bit          hold_off_req = 1'b0;
    bit          hold_off = 1'b0;

    function automatic longint floor_div_pow2(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-(v + 1)) >>> s)) - 1;
    endfunction

    function automatic void resample_setpoint(logic [14:0] pot);
        longint duty, hall, q;
        duty = (r_divider != 0) ? (pot >> 3) / r_divider : 4095;
        if (duty < r_min_duty) duty = r_min_duty;
        m_desired = duty[11:0];
        m_high_gain = !(m_desired < r_gain_sw);
        if (r_period == 0) hall = 64'hFFFFFFFF;
        else hall = (longint'(r_hall_rate) * m_desired) / r_period;
        q = (hall != 0) ? (longint'(r_freq_khz) * 1000) / hall : 24'hFFFFFF;
        m_expected = (q > 24'hFFFFFF) ? 24'hFFFFFF : q[23:0];
        m_have_sp = 1'b1;
    endfunction

    // advance one PWM period and return the expected result
    function automatic period_out_t predict_period(period_in_t it);
        period_out_t r;
        longint e, integ, kp, ki, c, applied;
        bit samp;
        r = '0;
        samp = 1'b0;
        m_ctrl_cnt = m_ctrl_cnt + 8'd1;
        m_samp_cnt = m_samp_cnt + 16'd1;
        if (m_ctrl_cnt > r_ctrl_intv) begin
            m_pending = 1'b1;
            m_ctrl_cnt = '0;
        end
        if (m_samp_cnt > r_sample_intv) begin
            m_samp_cnt = '0;
            samp = 1'b1;
        end
        if (samp || !m_have_sp) begin
            resample_setpoint(it.pot);
            samp = 1'b1;
        end
        if (m_pending && it.meas != 0) begin
            e = longint'(m_expected) - longint'(it.meas);
            integ = m_integ + e;
            if (integ > 64'sd2147483647) integ = 64'sd2147483647;
            if (integ < -64'sd2147483648) integ = -64'sd2147483648;
            m_integ = integ;
            kp = m_high_gain ? 4000 : 500;
            ki = m_high_gain ? 1 : 0;
            c = floor_div_pow2(kp * e + ki * integ, 14) / 3;
            c = floor_div_pow2(c, 3);
            applied = longint'(m_desired) + c;
            if (applied < longint'(r_min_duty)) begin
                applied = r_min_duty;
                m_integ = 0;
                r.clamp = 2'd1;
            end
            if (applied > longint'(r_period)) begin
                applied = r_period;
                m_integ = 0;
                r.clamp = 2'd2;
            end
            m_duty = applied[11:0];
            m_pending = 1'b0;
            r.ran = 1'b1;
        end
        r.duty = m_duty;
        r.sp_upd = samp;
        return r;
    endfunction

    // queue a stimulus period for the driver; the driver predicts it when it transfers
    task automatic queue_period(logic [14:0] pot, logic [23:0] meas);
        period_in_t it;
        it.pot = pot;
        it.meas = meas;
        pending_periods.push_back(it);
    endtask

    task automatic write_reg(bspc_pkg::reg_idx_t idx, int unsigned val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[bspc_pkg::CfgDataW-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bspc_pkg::REG_MIN_DUTY:    r_min_duty = val[11:0];
            bspc_pkg::REG_GAIN_SWITCH: r_gain_sw = val[11:0];
            bspc_pkg::REG_PWM_PERIOD:  r_period = val[11:0];
            bspc_pkg::REG_MAX_HALL:    r_hall_rate = val[15:0];
            bspc_pkg::REG_CNT_FREQ:    r_freq_khz = val[16:0];
            bspc_pkg::REG_CTRL_INTV:   r_ctrl_intv = val[7:0];
            bspc_pkg::REG_SAMPLE_INTV: r_sample_intv = val[15:0];
            default:                   r_divider = val[7:0];
        endcase
    endtask

    // wait until every queued period has transferred and its result arrived
    task automatic drain;
        while (pending_periods.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_meas();
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return 24'(m_expected + $urandom_range(0, 64) - 32);
            3: return 24'($urandom_range(1, 2000));
            default: return 24'($urandom());
        endcase
    endfunction

    // driver: present queued periods, predict on each transfer
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_period(pending_periods.pop_front()));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_periods.size() > 0 &&
                    $urandom_range(0, 99) >= in_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= 40'(pending_periods[0]);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off: refuse results for a long stretch once requested
    initial begin
        wait (hold_off_req);
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
    end

    // monitor: random back-pressure and comparison against the predictor
    always @(posedge clk or negedge rst_n) begin
        period_out_t got, want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h", m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: duty %0d/%0d ran %b/%b sp %b/%b clamp %0d/%0d",
                                     want.duty, got.duty, want.ran, got.ran,
                                     want.sp_upd, got.sp_upd, want.clamp, got.clamp);
                    end
                end
            end
            if (hold_off) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= out_stall_pct);
            end
        end
    end

    initial begin
        #60ms;
        $display("bldc_speed_pi_controller regression: fail");
        $finish;
    end

    initial begin
        r_min_duty = 410; r_gain_sw = 1024; r_period = 4095; r_hall_rate = 1000;
        r_freq_khz = 72000; r_ctrl_intv = 9; r_sample_intv = 99; r_divider = 1;
        m_ctrl_cnt = 0; m_samp_cnt = 0; m_pending = 0; m_have_sp = 0; m_high_gain = 0;
        m_desired = 0; m_duty = 0; m_expected = 0; m_integ = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: fast scheduling, field extremes, gain regions, clamps
        write_reg(bspc_pkg::REG_CTRL_INTV, 0);
        write_reg(bspc_pkg::REG_SAMPLE_INTV, 0);
        queue_period(15'd0, 24'd0);
        queue_period(15'd32767, 24'hFFFFFF);
        queue_period(15'd32767, 24'd1);
        queue_period(15'd0, 24'd5);
        queue_period(15'd8000, 24'd0);
        queue_period(15'd8000, 24'd12);
        queue_period(15'h5555, 24'h555555);
        queue_period(15'h2AAA, 24'hAAAAAA);
        drain();
        write_reg(bspc_pkg::REG_SPEED_DIV, 0);
        write_reg(bspc_pkg::REG_MIN_DUTY, 4095);
        write_reg(bspc_pkg::REG_PWM_PERIOD, 100);
        queue_period(15'd100, 24'd3);
        queue_period(15'd100, 24'd90000);
        drain();
        write_reg(bspc_pkg::REG_PWM_PERIOD, 0);
        write_reg(bspc_pkg::REG_SPEED_DIV, 255);
        write_reg(bspc_pkg::REG_MIN_DUTY, 0);
        queue_period(15'd1000, 24'd7);
        drain();
        write_reg(bspc_pkg::REG_MAX_HALL, 0);
        write_reg(bspc_pkg::REG_PWM_PERIOD, 4095);
        queue_period(15'd1000, 24'd7);
        drain();
        write_reg(bspc_pkg::REG_MAX_HALL, 65535);
        write_reg(bspc_pkg::REG_PWM_PERIOD, 1);
        write_reg(bspc_pkg::REG_CNT_FREQ, 100000);
        write_reg(bspc_pkg::REG_GAIN_SWITCH, 0);
        queue_period(15'd4000, 24'd1);
        queue_period(15'd4000, 24'hFFFFFF);
        drain();
        write_reg(bspc_pkg::REG_CTRL_INTV, 255);
        write_reg(bspc_pkg::REG_SAMPLE_INTV, 65535);
        write_reg(bspc_pkg::REG_GAIN_SWITCH, 4095);
        write_reg(bspc_pkg::REG_CNT_FREQ, 1);
        queue_period(15'd123, 24'd44);
        queue_period(15'd321, 24'd55);
        drain();

        // random phases over several register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 82; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 82; end
                default: begin in_idle_pct = 32; out_stall_pct = 32; end
            endcase
            write_reg(bspc_pkg::REG_MIN_DUTY, (ph == 7) ? 4095 : $urandom_range(0, 800));
            write_reg(bspc_pkg::REG_GAIN_SWITCH, $urandom_range(0, 4095));
            write_reg(bspc_pkg::REG_PWM_PERIOD, (ph == 6) ? 1 : $urandom_range(1, 4095));
            write_reg(bspc_pkg::REG_MAX_HALL, $urandom_range(0, 65535));
            write_reg(bspc_pkg::REG_CNT_FREQ, $urandom_range(1, 100000));
            write_reg(bspc_pkg::REG_CTRL_INTV, $urandom_range(0, 6));
            write_reg(bspc_pkg::REG_SAMPLE_INTV, $urandom_range(0, 12));
            write_reg(bspc_pkg::REG_SPEED_DIV, (ph == 5) ? 255 : $urandom_range(1, 8));
            if (ph == 2) hold_off_req = 1'b1;
            for (int k = 0; k < 205; k++)
                queue_period(15'($urandom_range(0, 32767)), rand_meas());
            drain();
        end
        if (mismatch_count == 0)
            $display("bldc_speed_pi_controller regression: pass");
        else
            $display("bldc_speed_pi_controller regression: fail");
        $finish;
    end
endmodule
